// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the PCM mixer.
// Each macro turns into nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("never failed");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== hw/rtl/spm_pkg.sv =====
// Package for the stereo PCM mixer: command codes, constants and the queue entry type.
// Used by every module of the mixer; depends on nothing.
`timescale 1ns / 1ps
package spm_pkg;
    localparam int CHANNELS_DEF     = 8;
    localparam int SAMPLE_DEPTH_DEF = 4096;
    localparam int CMD_W  = 3;
    localparam int TDATA_W = 64;   // 58 bits of fields, padded to bytes
    localparam int MDATA_W = 40;

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_START  = 3'd1,
        CMD_PARAMS = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  channel_index;
        logic [11:0] sample_address;
        logic [7:0]  sample_byte;
        logic [15:0] sound_length;
        logic [7:0]  volume;
        logic [7:0]  separation;
    } item_t;
endpackage

// ===== hw/rtl/spm_front.sv =====
// Front end of the PCM mixer: input handshake, unpacking, and a two-entry command queue.
// Depends on spm_pkg.
`timescale 1ns / 1ps
module spm_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [spm_pkg::TDATA_W-1:0] s_tdata,
    output logic                        q_valid,
    input  logic                        q_pop,
    output spm_pkg::item_t              q_item
);
    spm_pkg::item_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    spm_pkg::item_t in_item;
    logic push;

    assign in_item = '{command: s_tdata[2:0], channel_index: s_tdata[5:3],
                       sample_address: s_tdata[17:6], sample_byte: s_tdata[25:18],
                       sound_length: s_tdata[41:26], volume: s_tdata[49:42],
                       separation: s_tdata[57:50]};
    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (q_pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== hw/rtl/spm_back.sv =====
// Back end of the PCM mixer: channel state, sample memory and the serial mix engine.
// Depends on spm_pkg.
`timescale 1ns / 1ps
module spm_back #(
    parameter int CHANNELS     = spm_pkg::CHANNELS_DEF,
    parameter int SAMPLE_DEPTH = spm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_pop,
    input  spm_pkg::item_t q_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_left,
    output logic [15:0]    m_right,
    output logic [7:0]     m_mask,
    output logic           busy
);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int LW = AW + 1;
    localparam int MW = CW + AW;

    // Divide by 254 as a reciprocal multiply: ceil(2^31 / 254), exact below 2^23.
    localparam logic [23:0] RECIP   = 24'd8454661;
    // Magnitudes at or above these clamp: 32768 * 254 and 32769 * 254.
    localparam logic [31:0] OVF_POS = 32'd8323072;
    localparam logic [31:0] OVF_NEG = 32'd8323326;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001, ST_READ = 7'b0000010, ST_MUL = 7'b0000100,
        ST_ACC  = 7'b0001000, ST_OUT  = 7'b0010000, ST_DIV = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    logic [7:0]    mem [CHANNELS*SAMPLE_DEPTH];
    logic [LW-1:0] pos_reg [CHANNELS];
    logic [LW-1:0] len_reg [CHANNELS];
    logic [6:0]    vol_reg [CHANNELS];
    logic [7:0]    lg_reg  [CHANNELS];
    logic [7:0]    rg_reg  [CHANNELS];

    state_t        st_reg;
    logic [CW:0]   ch_reg;
    logic [7:0]    rd_reg;
    logic          act_reg;
    logic signed [15:0] sv_reg;
    logic signed [24:0] pl_reg, pr_reg;
    logic signed [31:0] sl_reg, sr_reg;
    logic [7:0]    mask_reg;
    logic          ov_reg;
    logic [15:0]   ol_reg, or_reg;
    logic [7:0]    om_reg;
    logic [22:0]   mag_l_reg, mag_r_reg;
    logic          neg_l_reg, neg_r_reg;
    logic          ovf_l_reg, ovf_r_reg;

    logic [CW-1:0] ch, qch;
    logic          qch_ok;
    logic [6:0]    vsat;
    logic [7:0]    ssat;
    logic [LW-1:0] lsat;
    logic [AW-1:0] qaddr, paddr;
    logic          cur_act;
    logic [31:0]   abs_l, abs_r;
    logic [46:0]   prod_l, prod_r;
    logic          fin_go;

    assign ch     = ch_reg[CW-1:0];
    assign qch    = CW'(q_item.channel_index);
    assign qch_ok = ({29'd0, q_item.channel_index} < 32'(CHANNELS));
    assign vsat   = (q_item.volume > 8'd127) ? 7'd127 : q_item.volume[6:0];
    assign ssat   = (q_item.separation > 8'd254) ? 8'd254 : q_item.separation;
    assign lsat   = ({16'd0, q_item.sound_length} > 32'(SAMPLE_DEPTH)) ?
                    LW'(SAMPLE_DEPTH) : LW'(q_item.sound_length);
    assign qaddr  = AW'(q_item.sample_address);
    assign paddr  = pos_reg[ch][AW-1:0];
    assign cur_act = pos_reg[ch] < len_reg[ch];
    assign q_pop  = q_valid && (st_reg == ST_IDLE);
    assign busy   = (st_reg != ST_IDLE) || ov_reg;
    assign m_tvalid = ov_reg;
    assign m_left = ol_reg;
    assign m_right = or_reg;
    assign m_mask = om_reg;

    assign abs_l  = sl_reg[31] ? (32'd0 - $unsigned(sl_reg)) : $unsigned(sl_reg);
    assign abs_r  = sr_reg[31] ? (32'd0 - $unsigned(sr_reg)) : $unsigned(sr_reg);
    assign prod_l = {24'd0, mag_l_reg} * {23'd0, RECIP};
    assign prod_r = {24'd0, mag_r_reg} * {23'd0, RECIP};
    assign fin_go = (st_reg == ST_FIN) && (!ov_reg || m_tready);

    // Apply sign and clamp to the truncated quotient.
    function automatic logic [15:0] fin(input logic neg, input logic ovf,
                                        input logic [15:0] q);
        if (ovf) return neg ? 16'h8000 : 16'h7fff;
        return neg ? (16'd0 - q) : q;
    endfunction

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (q_pop && q_item.command == spm_pkg::CMD_WRITE && qch_ok &&
            {20'd0, q_item.sample_address} < 32'(SAMPLE_DEPTH))
            mem[MW'({qch, qaddr})] <= q_item.sample_byte;
        rd_reg <= mem[MW'({ch, paddr})];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            ch_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                pos_reg[i] <= '0; len_reg[i] <= '0; vol_reg[i] <= '0;
                lg_reg[i] <= '0; rg_reg[i] <= '0;
            end
        end else begin
            if (fin_go) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: if (q_pop) begin
                    if (q_item.command == spm_pkg::CMD_TICK) begin
                        st_reg <= ST_READ; ch_reg <= '0;
                        sl_reg <= '0; sr_reg <= '0; mask_reg <= '0;
                    end else if (qch_ok) begin
                        case (q_item.command)
                            spm_pkg::CMD_START: begin
                                pos_reg[qch] <= '0; len_reg[qch] <= lsat;
                                if (lsat != '0) begin
                                    vol_reg[qch] <= vsat;
                                    lg_reg[qch] <= 8'd254 - ssat; rg_reg[qch] <= ssat;
                                end
                            end
                            spm_pkg::CMD_PARAMS: begin
                                vol_reg[qch] <= vsat;
                                lg_reg[qch] <= 8'd254 - ssat; rg_reg[qch] <= ssat;
                            end
                            spm_pkg::CMD_STOP: begin
                                pos_reg[qch] <= '0; len_reg[qch] <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    act_reg <= cur_act;
                    if (cur_act) begin
                        mask_reg <= mask_reg | (8'd1 << ch_reg);
                        pos_reg[ch] <= pos_reg[ch] + 1'b1;
                    end
                    st_reg <= ST_MUL;
                end
                ST_MUL: begin
                    sv_reg <= act_reg ? ($signed({8'd0, rd_reg}) - 16'sd128) *
                              $signed({9'd0, vol_reg[ch]}) : 16'sd0;
                    st_reg <= ST_ACC;
                end
                ST_ACC: begin
                    pl_reg <= sv_reg * $signed({17'd0, lg_reg[ch]});
                    pr_reg <= sv_reg * $signed({17'd0, rg_reg[ch]});
                    st_reg <= ST_OUT;
                end
                ST_OUT: begin
                    sl_reg <= sl_reg + 32'(pl_reg);
                    sr_reg <= sr_reg + 32'(pr_reg);
                    if (ch_reg == (CW+1)'(CHANNELS-1)) begin
                        st_reg <= ST_DIV;
                    end else begin
                        ch_reg <= ch_reg + 1'b1;
                        st_reg <= ST_READ;
                    end
                end
                ST_DIV: begin
                    // Split each sum into sign, magnitude and clamp flag.
                    neg_l_reg <= sl_reg[31];
                    neg_r_reg <= sr_reg[31];
                    mag_l_reg <= abs_l[22:0];
                    mag_r_reg <= abs_r[22:0];
                    ovf_l_reg <= abs_l >= (sl_reg[31] ? OVF_NEG : OVF_POS);
                    ovf_r_reg <= abs_r >= (sr_reg[31] ? OVF_NEG : OVF_POS);
                    st_reg <= ST_FIN;
                end
                ST_FIN: if (fin_go) begin
                    ol_reg <= fin(neg_l_reg, ovf_l_reg, prod_l[46:31]);
                    or_reg <= fin(neg_r_reg, ovf_r_reg, prod_r[46:31]);
                    om_reg <= mask_reg;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/multichannel_stereo_pcm_mixer.sv =====
// Stereo PCM mixer: a 2-entry queue feeds a back end that runs one command at a time.
// A tick's result raises m_tvalid after read, scale, gain and sum for each channel in turn, then the
// divide by 254 (states DIV and FIN); other commands take effect as the idle back end pops them.
// The back end pops the next command only once it is idle again, so ticks never overlap, and
// a pending result stalls the back end while m_tready is low.
// Reset: aresetn low (synchronous) clears queue, channel state and m_tvalid; samples stay.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multichannel_stereo_pcm_mixer #(
    parameter int CHANNELS     = spm_pkg::CHANNELS_DEF,
    parameter int SAMPLE_DEPTH = spm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0] channel_index[5:3] sample_address[17:6] sample_byte[25:18]
    // sound_length[41:26] volume[49:42] separation[57:50]
    input  logic [spm_pkg::TDATA_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_sample[15:0] right_sample[31:16] playing_mask[39:32]
    output logic [spm_pkg::MDATA_W-1:0] m_tdata
);
    logic q_valid, q_pop, busy;
    spm_pkg::item_t q_item;
    logic [15:0] l, r;
    logic [7:0]  mk;

    // Accept and queue commands.
    spm_front u_front (.aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
                       .q_valid, .q_pop, .q_item);

    // Execute commands and mix ticks.
    spm_back #(.CHANNELS(CHANNELS), .SAMPLE_DEPTH(SAMPLE_DEPTH)) u_back (
        .aclk, .aresetn, .q_valid, .q_pop, .q_item, .m_tvalid, .m_tready,
        .m_left(l), .m_right(r), .m_mask(mk), .busy);

    assign m_tdata = {mk, r, l};

    // Pop only with a queued command present.
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, q_pop && !q_valid)
    // A pending result holds until taken.
    `ASSERT_IMPL(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // Back end is busy whenever a result is pending.
    `ASSERT_NEVER(a_busy, aclk, aresetn, m_tvalid && !busy)
endmodule

// ===== test/tb_multichannel_stereo_pcm_mixer.sv =====
// Self-checking testbench for the stereo PCM mixer: directed and random command streams,
// a predicting mixer model and a scoreboard on the result stream. Depends on spm_pkg.
`timescale 1ns / 1ps
module tb_multichannel_stereo_pcm_mixer;

    localparam int NCH   = 8;
    localparam int DEPTH = 4096;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [7:0]         mask;
    } mix_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // command, channel_index, sample_address, sample_byte, sound_length, volume, separation
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // left_sample, right_sample, playing_mask
    logic [39:0] m_tdata;

    multichannel_stereo_pcm_mixer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mixer state mirrored by the predictor.
    logic [7:0]  pcm_mem [NCH][DEPTH];
    logic [12:0] pos_q [NCH];
    logic [12:0] len_q [NCH];
    logic [6:0]  vol_q [NCH];
    logic [7:0]  lgain_q [NCH];
    logic [7:0]  rgain_q [NCH];
    // Addresses written per channel, so a channel never plays past written data.
    int          written_to [NCH];

    spm_pkg::item_t pending_cmds[$];
    mix_t  expected_mix[$];
    int    errors = 0;
    int    sender_idle = 0;
    int    receiver_stall = 0;
    int    hold_off = 0;
    bit    stim_done = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void set_pan(input int ch, input logic [7:0] v, input logic [7:0] s);
        logic [7:0] sv;
        sv = (s > 8'd254) ? 8'd254 : s;
        vol_q[ch] = (v > 8'd127) ? 7'd127 : v[6:0];
        lgain_q[ch] = 8'd254 - sv;
        rgain_q[ch] = sv;
    endfunction

    // Advance the mirrored state by one command; queue the mix a tick produces.
    function automatic void mix_predict(input spm_pkg::item_t it);
        longint sum_l, sum_r, smp;
        logic [7:0] mask;
        int ch, ln;
        ch = it.channel_index;
        case (spm_pkg::cmd_t'(it.command))
            spm_pkg::CMD_TICK: begin
                sum_l = 0; sum_r = 0; mask = '0;
                for (int c = 0; c < NCH; c++) begin
                    if (pos_q[c] < len_q[c]) begin
                        mask[c] = 1'b1;
                        smp = (longint'(pcm_mem[c][pos_q[c]]) - 128) * vol_q[c];
                        sum_l += smp * lgain_q[c];
                        sum_r += smp * rgain_q[c];
                        pos_q[c]++;
                    end
                end
                sum_l = sum_l / 254;
                sum_r = sum_r / 254;
                if (sum_l > 32767) sum_l = 32767;
                if (sum_l < -32768) sum_l = -32768;
                if (sum_r > 32767) sum_r = 32767;
                if (sum_r < -32768) sum_r = -32768;
                expected_mix.push_back('{sum_l[15:0], sum_r[15:0], mask});
            end
            spm_pkg::CMD_WRITE: pcm_mem[ch][it.sample_address] = it.sample_byte;
            spm_pkg::CMD_START: begin
                ln = (it.sound_length > DEPTH) ? DEPTH : it.sound_length;
                pos_q[ch] = '0;
                len_q[ch] = ln[12:0];
                if (ln != 0) set_pan(ch, it.volume, it.separation);
            end
            spm_pkg::CMD_PARAMS: set_pan(ch, it.volume, it.separation);
            spm_pkg::CMD_STOP: begin
                pos_q[ch] = '0;
                len_q[ch] = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic spm_pkg::item_t make_cmd(input spm_pkg::cmd_t c, input int ch,
                                                input int addr, input int b, input int ln,
                                                input int v, input int s);
        spm_pkg::item_t it;
        it.command = c;
        it.channel_index = ch[2:0];
        it.sample_address = addr[11:0];
        it.sample_byte = b[7:0];
        it.sound_length = ln[15:0];
        it.volume = v[7:0];
        it.separation = s[7:0];
        return it;
    endfunction

    // Pack the fields into tdata, command in the lowest bits.
    function automatic logic [63:0] pack_item(input spm_pkg::item_t it);
        return {6'd0, it.separation, it.volume, it.sound_length, it.sample_byte,
                it.sample_address, it.channel_index, it.command};
    endfunction

    function automatic spm_pkg::item_t random_noise();
        spm_pkg::item_t it;
        it = make_cmd(spm_pkg::cmd_t'(3'($urandom_range(7))), $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        return it;
    endfunction

    // Queue a write, keeping track of how far each channel has written data.
    function automatic void push_write(input int ch, input int addr, input int b);
        spm_pkg::item_t it;
        it = make_cmd(spm_pkg::CMD_WRITE, ch, addr, b, $urandom, $urandom, $urandom);
        pending_cmds.push_back(it);
        if (addr == written_to[ch]) written_to[ch]++;
    endfunction

    // Start only over the written prefix, so no tick reads an unwritten entry.
    function automatic void push_start(input int ch, input int ln, input int v, input int s);
        ln = ln & 32'h0000ffff;
        if (written_to[ch] < DEPTH && ln > written_to[ch]) ln = written_to[ch];
        pending_cmds.push_back(make_cmd(spm_pkg::CMD_START, ch, $urandom, $urandom,
                                        ln, v, s));
    endfunction

    // Driver: present the head of the queue, idle at random between transactions.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                mix_predict(pending_cmds.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() > 0 && !($urandom_range(99) < sender_idle)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pack_item(pending_cmds[0]);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Count down a long receiver hold-off.
    always @(posedge aclk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // Monitor: compare each result with the oldest expectation; stall at random.
    always @(posedge aclk) begin
        mix_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.left = m_tdata[15:0];
                got.right = m_tdata[31:16];
                got.mask = m_tdata[39:32];
                if (expected_mix.size() == 0) begin
                    report_mismatch("unexpected result", 0, 1);
                end else begin
                    want = expected_mix.pop_front();
                    if (got.left != want.left) report_mismatch("left", got.left, want.left);
                    if (got.right != want.right)
                        report_mismatch("right", got.right, want.right);
                    if (got.mask != want.mask) report_mismatch("mask", got.mask, want.mask);
                end
            end
            if (hold_off > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= !($urandom_range(99) < receiver_stall);
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_mix.size() != 0)
            @(posedge aclk);
    endtask

    // One burst of well-formed play traffic with some noise mixed in.
    task automatic random_phase(input int n);
        int ch, k;
        for (int i = 0; i < n; i++) begin
            ch = $urandom_range(NCH - 1);
            k = $urandom_range(99);
            if (k < 30) push_write(ch, written_to[ch] < DEPTH && $urandom_range(3) != 0 ?
                                   written_to[ch] : $urandom_range(DEPTH - 1),
                                   $urandom_range(255));
            else if (k < 40) push_start(ch, $urandom_range(3) == 0 ? $urandom :
                                        $urandom_range(40), $urandom, $urandom);
            else if (k < 47) pending_cmds.push_back(make_cmd(spm_pkg::CMD_PARAMS, ch,
                                        $urandom, $urandom, $urandom, $urandom, $urandom));
            else if (k < 50) pending_cmds.push_back(make_cmd(spm_pkg::CMD_STOP, ch,
                                        $urandom, $urandom, $urandom, $urandom, $urandom));
            else if (k < 95) pending_cmds.push_back(make_cmd(spm_pkg::CMD_TICK, ch,
                                        $urandom, $urandom, $urandom, $urandom, $urandom));
            else begin
                spm_pkg::item_t it;
                it = random_noise();
                // Keep noise away from starts, which could replay unwritten entries.
                if (it.command == spm_pkg::CMD_START) it.command = spm_pkg::CMD_STOP;
                pending_cmds.push_back(it);
            end
        end
    endtask

    initial begin
        for (int c = 0; c < NCH; c++) begin
            pos_q[c] = '0; len_q[c] = '0; vol_q[c] = '0;
            lgain_q[c] = '0; rgain_q[c] = '0; written_to[c] = 0;
            for (int a = 0; a < DEPTH; a++) pcm_mem[c][a] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: tick on idle mixer, extremes of samples, volume and pan.
        pending_cmds.push_back(make_cmd(spm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        push_write(0, 0, 255); push_write(0, 1, 0); push_write(0, 2, 128);
        push_write(1, 0, 0); push_write(1, 1, 255);
        push_write(2, 0, 255); push_write(3, 0, 255);
        push_write(7, 4095, 77);            // top address of the last channel
        push_start(0, 65535, 255, 255);     // volume and pan saturate
        push_start(1, 2, 127, 0);           // full left
        push_start(2, 1, 255, 127);
        push_start(3, 1, 255, 254);         // full right, sum clamps
        pending_cmds.push_back(make_cmd(spm_pkg::CMD_TICK, 5, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(spm_pkg::CMD_PARAMS, 0, 0, 0, 0, 0, 200));
        pending_cmds.push_back(make_cmd(spm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        push_start(1, 0, 9, 9);             // zero length stops, gains stay
        pending_cmds.push_back(make_cmd(spm_pkg::CMD_STOP, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(spm_pkg::cmd_t'(3'd5), 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(spm_pkg::cmd_t'(3'd7), 2, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(spm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(spm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Fill every channel with loud data for clamp-heavy mixing.
        for (int c = 0; c < NCH; c++)
            for (int a = 0; a < 64; a++) push_write(c, a, $urandom_range(1) ? 255 : 0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 73) : 0;
            receiver_stall = (ph == 2) ? 73 : (ph == 3) ? 22 : 0;
            random_phase(250);
            if (ph == 0) begin
                // Hold the result side off long enough for the input to back up.
                while (pending_cmds.size() > 200) @(posedge aclk);
                hold_off <= 400;
            end
            wait_drained();
        end
        sender_idle = 0;
        receiver_stall = 0;
        random_phase(200);
        wait_drained();
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule
